// File: hdl/mte_pkg.sv
// Shared types, code tables and lookup functions for the Morse text encoder.
package mte_pkg;

    localparam logic [15:0] GAP_CODE   = 16'h0020;
    localparam logic [15:0] SPACE_CODE = 16'h0020;
    localparam logic [15:0] ERR_CODE   = 16'h0000;

    localparam logic [15:0] RST_SHORT_CHAR = 16'd46;
    localparam logic [15:0] RST_LONG_CHAR  = 16'd45;
    localparam logic [15:0] RST_DELIM_CHAR = 16'd47;

    typedef enum logic [1:0] {
        CFG_ALPHABET   = 2'd0,
        CFG_SHORT_CHAR = 2'd1,
        CFG_LONG_CHAR  = 2'd2,
        CFG_DELIM_CHAR = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_DELIM   = 2'd0,
        KIND_UNKNOWN = 2'd1,
        KIND_SYMBOL  = 2'd2
    } t_kind;

    // len: element count; bits: elements left aligned, bit 6 first, 1 = long
    typedef struct packed {
        logic [2:0] len;
        logic [6:0] bits;
    } t_pat;

    typedef struct packed {
        t_kind kind;
        logic  gap;
        t_pat  pat;
    } t_job;

    typedef struct packed {
        logic found;
        t_pat pat;
    } t_look;

    typedef struct packed {
        logic [15:0] short_char;
        logic [15:0] long_char;
        logic [15:0] delim_char;
    } t_codes;

    localparam logic [9:0] LATIN_TAB [0:25] = '{
        10'b010_0100000, 10'b100_1000000, 10'b100_1010000, 10'b011_1000000,
        10'b001_0000000, 10'b100_0010000, 10'b011_1100000, 10'b100_0000000,
        10'b010_0000000, 10'b100_0111000, 10'b011_1010000, 10'b100_0100000,
        10'b010_1100000, 10'b010_1000000, 10'b011_1110000, 10'b100_0110000,
        10'b100_1101000, 10'b011_0100000, 10'b011_0000000, 10'b001_1000000,
        10'b011_0010000, 10'b100_0001000, 10'b011_0110000, 10'b100_1001000,
        10'b100_1011000, 10'b100_1100000
    };

    localparam logic [9:0] CYR_TAB [0:31] = '{
        10'b010_0100000, 10'b100_1000000, 10'b011_0110000, 10'b011_1100000,
        10'b011_1000000, 10'b001_0000000, 10'b100_0001000, 10'b100_1100000,
        10'b010_0000000, 10'b100_0111000, 10'b011_1010000, 10'b100_0100000,
        10'b010_1100000, 10'b010_1000000, 10'b011_1110000, 10'b100_0110000,
        10'b011_0100000, 10'b011_0000000, 10'b001_1000000, 10'b011_0010000,
        10'b100_0010000, 10'b100_0000000, 10'b100_1010000, 10'b100_1110000,
        10'b100_1111000, 10'b100_1101000, 10'b101_1101100, 10'b100_1011000,
        10'b100_1001000, 10'b101_0010000, 10'b100_0011000, 10'b100_0101000
    };

    localparam logic [9:0] DIGIT_TAB [0:9] = '{
        10'b101_1111100, 10'b101_0111100, 10'b101_0011100, 10'b101_0001100,
        10'b101_0000100, 10'b101_0000000, 10'b101_1000000, 10'b101_1100000,
        10'b101_1110000, 10'b101_1111000
    };

    function automatic logic [15:0] to_lower(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c >= 16'h0041 && c <= 16'h005A) begin
            r = c + 16'h0020;
        end else if (c >= 16'h0410 && c <= 16'h042F) begin
            r = c + 16'h0020;
        end else if (c == 16'h0401) begin
            r = 16'h0451;
        end
        return r;
    endfunction

    function automatic t_pat punct_pat(input logic [15:0] c, output logic found);
        t_pat p;
        p     = '0;
        found = 1'b1;
        unique case (c)
            16'h002E: p = 10'b110_0101010;
            16'h002C: p = 10'b110_1100110;
            16'h003F: p = 10'b110_0011000;
            16'h2014: p = 10'b110_1000010;
            16'h003A: p = 10'b110_1110000;
            16'h003B: p = 10'b110_1010100;
            16'h0021: p = 10'b110_1010110;
            16'h0027: p = 10'b110_0111100;
            16'h0022: p = 10'b110_0100100;
            16'h0028: p = 10'b101_1011000;
            16'h0029: p = 10'b110_1011010;
            16'h0026: p = 10'b101_0100000;
            16'h002F: p = 10'b101_1001000;
            16'h005F: p = 10'b110_0011010;
            16'h003D: p = 10'b101_1000100;
            16'h002B: p = 10'b101_0101000;
            16'h002D: p = 10'b110_1000010;
            16'h0024: p = 10'b111_0001001;
            16'h0040: p = 10'b110_0110100;
            default: found = 1'b0;
        endcase
        return p;
    endfunction

    function automatic t_look lookup(input logic [15:0] lc, input logic alpha);
        t_look       r;
        logic [15:0] c;
        logic        pf;
        t_pat        pp;
        r  = '0;
        c  = lc;
        pp = punct_pat(lc, pf);
        if (alpha && lc == 16'h0451) begin
            c = 16'h0435;
        end
        priority if (!alpha && c >= 16'h0061 && c <= 16'h007A) begin
            r.found = 1'b1;
            r.pat   = LATIN_TAB[5'(c - 16'h0061)];
        end else if (alpha && c >= 16'h0430 && c <= 16'h044F) begin
            r.found = 1'b1;
            r.pat   = CYR_TAB[5'(c - 16'h0430)];
        end else if (c >= 16'h0030 && c <= 16'h0039) begin
            r.found = 1'b1;
            r.pat   = DIGIT_TAB[4'(c - 16'h0030)];
        end else begin
            r.found = pf;
            r.pat   = pp;
        end
        return r;
    endfunction

endpackage

// File: hdl/morse_text_encoder.sv
// Morse text encoder top level: configuration registers, front end, queue, back end.
// A request is written into a queue slot; its first result then lands in the back end's output register.
// One result per cycle while not stalled; a request with 1 to 8 results holds the back end until its last.
// The emit loop sets the rate; the front end takes one request per cycle while the queue has room.
// Reset (synchronous, active low) empties the queue, clears gap memory and output valid,
// and restores the configuration registers to their defaults.
module morse_text_encoder
    import mte_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_in_char,
    input  logic        i_starts_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_char,
    output logic        o_is_last,
    output logic        o_unknown_char
);

    logic   r_alphabet;
    t_codes r_codes;
    logic   push;
    logic   pop;
    logic   full;
    logic   nonempty;
    t_job   push_job;
    t_job   head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet         <= 1'b0;
            r_codes.short_char <= RST_SHORT_CHAR;
            r_codes.long_char  <= RST_LONG_CHAR;
            r_codes.delim_char <= RST_DELIM_CHAR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ALPHABET:   r_alphabet         <= i_cfg_data[0];
                CFG_SHORT_CHAR: r_codes.short_char <= i_cfg_data;
                CFG_LONG_CHAR:  r_codes.long_char  <= i_cfg_data;
                CFG_DELIM_CHAR: r_codes.delim_char <= i_cfg_data;
                default:        r_alphabet         <= r_alphabet;
            endcase
        end
    end

    mte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_char     (i_in_char),
        .i_starts_text (i_starts_text),
        .i_alphabet    (r_alphabet),
        .i_full        (full),
        .o_push        (push),
        .o_job         (push_job)
    );

    mte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head_job)
    );

    mte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_job),
        .i_head_valid   (nonempty),
        .o_pop          (pop),
        .i_codes        (r_codes),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_char     (o_out_char),
        .o_is_last      (o_is_last),
        .o_unknown_char (o_unknown_char)
    );

endmodule

// File: hdl/mte_front.sv
// Front end: accepts characters, classifies them and builds emit jobs.
module mte_front
    import mte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_in_char,
    input  logic        i_starts_text,
    input  logic        i_alphabet,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_prev_sym;
    logic        n_prev_sym;
    logic [15:0] lc;
    t_look       look;
    logic        prev;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        lc         = to_lower(i_in_char);
        look       = lookup(lc, i_alphabet);
        prev       = i_starts_text ? 1'b0 : r_prev_sym;
        o_job      = '0;
        n_prev_sym = 1'b0;
        priority if (lc == SPACE_CODE) begin
            o_job.kind = KIND_DELIM;
        end else if (!look.found) begin
            o_job.kind = KIND_UNKNOWN;
        end else begin
            o_job.kind = KIND_SYMBOL;
            o_job.gap  = prev;
            o_job.pat  = look.pat;
            n_prev_sym = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sym <= 1'b0;
        end else if (o_push) begin
            r_prev_sym <= n_prev_sym;
        end
    end

endmodule

// File: hdl/mte_queue.sv
// Job queue between front and back end.
module mte_queue
    import mte_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/mte_back.sv
// Back end: walks each job and emits one registered result per cycle while the output is not stalled.
module mte_back
    import mte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_head_valid,
    output logic        o_pop,
    input  t_codes      i_codes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_char,
    output logic        o_is_last,
    output logic        o_unknown_char
);

    logic        r_busy;
    t_job        r_job;
    logic        r_out_valid;
    logic [15:0] r_out_char;
    logic        r_is_last;
    logic        r_unknown;

    t_job        cur;
    t_job        rest;
    logic        cur_valid;
    logic        adv;
    logic [15:0] res_char;
    logic        res_last;
    logic        res_unk;

    always_comb begin
        cur       = r_busy ? r_job : i_head;
        cur_valid = r_busy || i_head_valid;
        adv       = cur_valid && (!r_out_valid || !i_stall);
        rest      = cur;
        res_char  = ERR_CODE;
        res_last  = 1'b1;
        res_unk   = 1'b0;
        unique case (cur.kind)
            KIND_DELIM: begin
                res_char = i_codes.delim_char;
            end
            KIND_SYMBOL: begin
                if (cur.gap) begin
                    res_char = GAP_CODE;
                    res_last = 1'b0;
                    rest.gap = 1'b0;
                end else begin
                    res_char      = cur.pat.bits[6] ? i_codes.long_char : i_codes.short_char;
                    res_last      = (cur.pat.len == 3'd1);
                    rest.pat.bits = {cur.pat.bits[5:0], 1'b0};
                    rest.pat.len  = cur.pat.len - 3'd1;
                end
            end
            default: begin
                res_unk = 1'b1;
            end
        endcase
        o_pop = adv && !r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_job      <= rest;
            r_out_char <= res_char;
            r_is_last  <= res_last;
            r_unknown  <= res_unk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_busy      <= !res_last;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_is_last      = r_is_last;
    assign o_unknown_char = r_unknown;

endmodule

// File: hdl/mte_checker.sv
// Port-level checks for the Morse text encoder, bound to the top level.
module mte_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_out_char,
    input logic        o_is_last,
    input logic        o_unknown_char
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_unknown_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unknown_char) |-> o_is_last)
        else $error("unknown result not marked last");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unknown_char) |-> (o_out_char == 16'h0000))
        else $error("unknown result carries a code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_char) && $stable(o_is_last)))
        else $error("stalled result changed");

endmodule

bind morse_text_encoder mte_port_checks u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_char     (o_out_char),
    .o_is_last      (o_is_last),
    .o_unknown_char (o_unknown_char)
);
